>>> src/cls_pkg.sv
// Package for the competitive learning step unit: beat types, cell control
// and compare token types, op codes and fixed widths. No dependencies.
package cls_pkg;

   localparam int DIST_W = 35;
   localparam int IDX_W = 4;
   localparam logic [33:0] DIST_SAT = 34'h3FFFFFFFF;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_TRAIN = 2'd1;
   localparam logic [1:0] OP_CLASSIFY = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic [1:0] neuron_index;
      logic signed [15:0] feature_0;
      logic signed [15:0] feature_1;
      logic signed [15:0] feature_2;
      logic signed [15:0] feature_3;
      logic signed [15:0] feature_4;
      logic signed [15:0] feature_5;
      logic signed [15:0] feature_6;
      logic signed [15:0] feature_7;
   } req_type;

   typedef struct packed {
      logic [1:0] winner;
      logic [33:0] min_distance;
      logic signed [15:0] weight_0;
      logic signed [15:0] weight_1;
      logic signed [15:0] weight_2;
      logic signed [15:0] weight_3;
      logic signed [15:0] weight_4;
      logic signed [15:0] weight_5;
      logic signed [15:0] weight_6;
      logic signed [15:0] weight_7;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic clr;
      logic acc;
      logic upd;
   } ctrl_type;

   typedef struct packed {
      logic found;
      logic [DIST_W-1:0] best;
      logic [IDX_W-1:0] idx;
   } token_type;

endpackage

>>> src/cls_cell.sv
// One neuron cell: holds its weight vector, accumulates its squared distance,
// passes the running minimum to the next cell and applies the learning update.
// Depends on cls_pkg.
module cls_cell #(
   parameter int FEATURES = 8,
   parameter int FIW = 3,
   parameter int ID = 0
) (
   input logic clock,
   input logic reset,
   input cls_pkg::ctrl_type ctrl,
   input logic [1:0] load_idx,
   input logic [FIW-1:0] feat,
   input logic [15:0] lr,
   input logic [cls_pkg::IDX_W-1:0] win,
   input logic signed [15:0] x_vec [FEATURES],
   input cls_pkg::token_type tin,
   output cls_pkg::token_type tout,
   output logic signed [15:0] w_out [FEATURES]
);
   import cls_pkg::*;

   logic signed [15:0] w_ff [FEATURES];
   logic [DIST_W-1:0] acc_ff, acc_in;
   token_type tok_ff, tok_in;
   logic signed [16:0] d;
   logic signed [33:0] sq, p, r;
   logic signed [19:0] step, sum;
   logic signed [15:0] nw;
   logic take;

   always_comb begin
      d = {x_vec[feat][15], x_vec[feat]} - {w_ff[feat][15], w_ff[feat]};
      sq = d * d;
      acc_in = acc_ff + {{(DIST_W-32){1'b0}}, sq[31:0]};
      p = $signed({1'b0, lr}) * d;
      r = p + 34'sd8192;
      step = r[33:14];
      sum = {{4{w_ff[feat][15]}}, w_ff[feat]} + step;
      if (sum > 20'sd32767) begin
         nw = 16'sh7FFF;
      end else if (sum < -20'sd32768) begin
         nw = 16'sh8000;
      end else begin
         nw = sum[15:0];
      end
      take = !tin.found || (acc_ff < tin.best);
      tok_in = take ? {1'b1, acc_ff, IDX_W'(ID)} : tin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.found <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
      if (ctrl.clr) begin
         acc_ff <= '0;
      end else if (ctrl.acc) begin
         acc_ff <= acc_in;
      end
      if (ctrl.load && ({2'b0, load_idx} == IDX_W'(ID))) begin
         w_ff <= x_vec;
      end else if (ctrl.upd && (win == IDX_W'(ID))) begin
         w_ff[feat] <= nw;
      end
   end

   assign tout = tok_ff;
   assign w_out = w_ff;

endmodule

>>> src/competitive_learning_step_unit.sv
// Top level of the competitive learning step unit: sequencer, beat registers
// and a chain of neuron cells. Depends on cls_pkg and cls_cell.
//
//   channel | direction | handshake      | beat
//   req     | in        | valid / stall  | op, neuron_index, feature_0..7
//   rsp     | out       | valid / stall  | winner, min_distance, weight_0..7
//   csr     | in        | valid / ready  | learning_rate
//
// A load passes through LOAD_S and OUT_S; a train runs DIST_S, CMP_S, UPD_S and OUT_S, a
// classify DIST_S, CMP_S and OUT_S: one feature squared per cycle in each cell, one cell
// per cycle along the compare chain, and one weight updated per cycle. The result turns
// valid as the unit returns to IDLE_S, before the next accept.
// Reset sets the learning rate to 1.5 and leaves weights unwritten.
// A new beat is taken while an earlier result waits under stall; the next result then
// holds in its last state until the waiting one is taken.
module competitive_learning_step_unit #(
   parameter int NEURONS = 4,
   parameter int FEATURES = 8
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input cls_pkg::req_type req,
   output logic rsp_valid,
   input logic rsp_stall,
   output cls_pkg::rsp_type rsp,
   input logic csr_valid,
   output logic csr_ready,
   input logic [15:0] csr_data
);
   import cls_pkg::*;

   localparam int FIW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
   localparam int NIW = $clog2(NEURONS);
   localparam int CMAX = (FEATURES > NEURONS) ? FEATURES : NEURONS;
   localparam int CW = $clog2(CMAX);

   typedef enum logic [2:0] {IDLE_S, LOAD_S, DIST_S, CMP_S, UPD_S, OUT_S} state_type;

   state_type state_ff;
   logic [CW-1:0] cnt_ff;
   req_type item_ff;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff;
   logic [15:0] lr_ff;
   ctrl_type ctrl;
   logic signed [15:0] x_all [8];
   logic signed [15:0] x_vec [FEATURES];
   logic signed [15:0] cw [NEURONS][FEATURES];
   token_type tok [NEURONS+1];
   logic signed [15:0] wsel [8];
   token_type last;
   logic out_load;

   assign req_stall = (state_ff != IDLE_S);
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;
   assign csr_ready = 1'b1;
   assign last = tok[NEURONS];
   assign out_load = (state_ff == OUT_S) && (!rsp_valid_ff || !rsp_stall);
   assign tok[0] = '0;

   always_comb begin
      x_all[0] = item_ff.feature_0;
      x_all[1] = item_ff.feature_1;
      x_all[2] = item_ff.feature_2;
      x_all[3] = item_ff.feature_3;
      x_all[4] = item_ff.feature_4;
      x_all[5] = item_ff.feature_5;
      x_all[6] = item_ff.feature_6;
      x_all[7] = item_ff.feature_7;
      for (int f = 0; f < FEATURES; f++) begin
         x_vec[f] = x_all[f];
      end
      ctrl.load = (state_ff == LOAD_S);
      ctrl.clr = (state_ff == IDLE_S);
      ctrl.acc = (state_ff == DIST_S);
      ctrl.upd = (state_ff == UPD_S);
   end

   for (genvar n = 0; n < NEURONS; n++) begin : g_cell
      cls_cell #(.FEATURES(FEATURES), .FIW(FIW), .ID(n)) u_cell (
         .clock(clock),
         .reset(reset),
         .ctrl(ctrl),
         .load_idx(item_ff.neuron_index),
         .feat(cnt_ff[FIW-1:0]),
         .lr(lr_ff),
         .win(last.idx),
         .x_vec(x_vec),
         .tin(tok[n]),
         .tout(tok[n+1]),
         .w_out(cw[n])
      );
   end

   always_comb begin
      for (int f = 0; f < 8; f++) begin
         wsel[f] = '0;
      end
      rsp_in.winner = item_ff.neuron_index;
      rsp_in.min_distance = '0;
      if (item_ff.op == OP_LOAD) begin
         if ({2'b0, item_ff.neuron_index} < IDX_W'(NEURONS)) begin
            for (int f = 0; f < FEATURES; f++) begin
               wsel[f] = x_all[f];
            end
         end
      end else begin
         rsp_in.winner = last.idx[1:0];
         rsp_in.min_distance = (last.best > {1'b0, DIST_SAT}) ? DIST_SAT : last.best[33:0];
         for (int f = 0; f < FEATURES; f++) begin
            wsel[f] = cw[last.idx[NIW-1:0]][f];
         end
      end
      rsp_in.weight_0 = wsel[0];
      rsp_in.weight_1 = wsel[1];
      rsp_in.weight_2 = wsel[2];
      rsp_in.weight_3 = wsel[3];
      rsp_in.weight_4 = wsel[4];
      rsp_in.weight_5 = wsel[5];
      rsp_in.weight_6 = wsel[6];
      rsp_in.weight_7 = wsel[7];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE_S;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         lr_ff <= 16'd24576;
      end else begin
         if (csr_valid && csr_ready) begin
            lr_ff <= csr_data;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE_S: begin
               cnt_ff <= '0;
               if (req_valid) begin
                  item_ff <= req;
                  state_ff <= (req.op == OP_LOAD) ? LOAD_S : DIST_S;
               end
            end
            LOAD_S: begin
               state_ff <= OUT_S;
            end
            DIST_S: begin
               if (cnt_ff == CW'(FEATURES - 1)) begin
                  cnt_ff <= '0;
                  state_ff <= CMP_S;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            CMP_S: begin
               if (cnt_ff == CW'(NEURONS - 1)) begin
                  cnt_ff <= '0;
                  state_ff <= (item_ff.op == OP_TRAIN) ? UPD_S : OUT_S;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            UPD_S: begin
               if (cnt_ff == CW'(FEATURES - 1)) begin
                  cnt_ff <= '0;
                  state_ff <= OUT_S;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            OUT_S: begin
               if (out_load) begin
                  rsp_ff <= rsp_in;
                  state_ff <= IDLE_S;
               end
            end
            default: begin
               state_ff <= IDLE_S;
            end
         endcase
      end
   end

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != IDLE_S) |-> req_stall)
      else $error("beat accepted while busy");
   a_win_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == UPD_S) |-> (last.found && (last.idx < IDX_W'(NEURONS))))
      else $error("winner out of range");
   a_load_dist: assert property (@(posedge clock) disable iff (reset)
      (out_load && (item_ff.op == OP_LOAD)) |=> (rsp_valid_ff && (rsp_ff.min_distance == '0)))
      else $error("load result with distance");

endmodule

>>> test/competitive_learning_step_unit_tb.sv
// Testbench for the competitive learning step unit: random and directed load, train
// and classify beats checked against a built-in model of the weight store.
// Depends on cls_pkg and the competitive_learning_step_unit RTL.
module competitive_learning_step_unit_tb;
   import cls_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [15:0] csr_data = '0;

   competitive_learning_step_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req(req),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic signed [15:0] weight_store [4][8];
   logic [15:0] model_rate;
   req_type pending_beats[$];
   rsp_type expected_results[$];
   int errors = 0;
   bit quiet = 1'b0;
   bit beat_taken = 1'b0;
   int send_gap = 0;
   int stall_left = 0;

   function automatic logic signed [15:0] feat(req_type r, int f);
      logic [127:0] v;
      v = r[127:0];
      return v[(7 - f) * 16 +: 16];
   endfunction

   function automatic void add_beat(req_type r);
      pending_beats = {pending_beats, r};
   endfunction

   function automatic rsp_type predict_result(req_type r);
      rsp_type o;
      logic [127:0] w;
      logic [34:0] d, best;
      logic signed [16:0] diff;
      logic signed [33:0] prod;
      logic signed [19:0] step;
      logic signed [20:0] nw;
      int win;
      o = '0;
      w = '0;
      best = '0;
      win = 0;
      if (r.op == OP_LOAD) begin
         o.winner = r.neuron_index;
         for (int f = 0; f < 8; f++) begin
            weight_store[r.neuron_index][f] = feat(r, f);
            w[(7 - f) * 16 +: 16] = feat(r, f);
         end
      end else begin
         for (int n = 0; n < 4; n++) begin
            d = '0;
            for (int f = 0; f < 8; f++) begin
               diff = 17'(feat(r, f)) - 17'(weight_store[n][f]);
               d += 35'(34'(diff * diff));
            end
            if (n == 0 || d < best) begin
               best = d;
               win = n;
            end
         end
         if (r.op == OP_TRAIN) begin
            for (int f = 0; f < 8; f++) begin
               diff = 17'(feat(r, f)) - 17'(weight_store[win][f]);
               prod = $signed({1'b0, model_rate}) * diff;
               step = 20'((prod + 34'sd8192) >>> 14);
               nw = 21'(weight_store[win][f]) + 21'(step);
               if (nw > 21'sd32767) nw = 21'sd32767;
               if (nw < -21'sd32768) nw = -21'sd32768;
               weight_store[win][f] = nw[15:0];
            end
         end
         for (int f = 0; f < 8; f++) w[(7 - f) * 16 +: 16] = weight_store[win][f];
         o.winner = 2'(win);
         o.min_distance = best[34] ? DIST_SAT : best[33:0];
      end
      o[127:0] = w;
      return o;
   endfunction

   // Driver: holds a beat until it is taken, gaps in random bursts.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || beat_taken) begin
            beat_taken = 1'b0;
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
               send_gap <= $urandom_range(0, 4);
               req_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               req_valid <= 1'b1;
               req <= pending_beats[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 4);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp);
            errors++;
         end else begin
            e = expected_results.pop_front();
            if (rsp.winner !== e.winner) begin
               $display("%0t: winner expected %0d actual %0d", $time, e.winner, rsp.winner);
               errors++;
            end
            if (rsp.min_distance !== e.min_distance) begin
               $display("%0t: min_distance expected %0d actual %0d", $time,
                        e.min_distance, rsp.min_distance);
               errors++;
            end
            for (int f = 0; f < 8; f++) begin
               if (rsp[(7 - f) * 16 +: 16] !== e[(7 - f) * 16 +: 16]) begin
                  $display("%0t: weight_%0d expected %h actual %h", $time, f,
                           e[(7 - f) * 16 +: 16], rsp[(7 - f) * 16 +: 16]);
                  errors++;
               end
            end
         end
      end
      if (!reset && req_valid && !req_stall) begin
         void'(pending_beats.pop_front());
         expected_results = {expected_results, predict_result(req)};
         beat_taken = 1'b1;
      end
   end

   function automatic logic [15:0] rand_value();
      case ($urandom_range(0, 5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 255)) - 16'd128;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type make_beat(logic [1:0] op, logic [1:0] idx, bit extreme);
      req_type r;
      r = '0;
      r.op = op;
      r.neuron_index = idx;
      for (int f = 0; f < 8; f++) r[(7 - f) * 16 +: 16] = extreme ? 16'h8000 : rand_value();
      return r;
   endfunction

   task automatic drain();
      while (pending_beats.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_rate(logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      model_rate = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_all();
      for (int n = 0; n < 4; n++) add_beat(make_beat(OP_LOAD, 2'(n), 0));
   endtask

   initial begin
      req_type r;
      logic [15:0] rates [5] = '{16'd0, 16'hFFFF, 16'd4096, 16'd16384, 16'd24576};
      model_rate = 16'd24576;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Directed: loads with both extremes, ties, every op including op three.
      for (int n = 0; n < 4; n++) begin
         r = make_beat(OP_LOAD, 2'(n), 1);
         if (n[0]) for (int f = 0; f < 8; f++) r[(7 - f) * 16 +: 16] = 16'h7FFF;
         add_beat(r);
      end
      r = make_beat(OP_CLASSIFY, 2'd0, 1);
      add_beat(r);
      for (int f = 0; f < 8; f++) r[(7 - f) * 16 +: 16] = 16'h7FFF;
      r.op = OP_TRAIN;
      add_beat(r);
      r.op = 2'd3;
      add_beat(r);
      r = make_beat(OP_TRAIN, 2'd3, 0);
      for (int f = 0; f < 8; f++) r[(7 - f) * 16 +: 16] = 16'h8000;
      add_beat(r);
      add_beat(make_beat(OP_CLASSIFY, 2'd1, 0));
      drain();
      for (int p = 0; p < 5; p++) begin
         write_rate(rates[p]);
         load_all();
         for (int i = 0; i < 150; i++) begin
            if ($urandom_range(0, 9) == 0)
               add_beat(make_beat(OP_LOAD, 2'($urandom), 0));
            else
               add_beat(make_beat(2'($urandom_range(1, 3)), 2'($urandom), 0));
         end
         if (p == 4) quiet = 1'b1;
         drain();
      end
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
